// File: rtl/cidr_text_parser_range_splitter_macros.svh
// Assertion helpers used by the splitter top level
`ifndef CIDR_TEXT_PARSER_RANGE_SPLITTER_MACROS_SVH
`define CIDR_TEXT_PARSER_RANGE_SPLITTER_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define CTRS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CTRS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ctrs_pkg.sv
package ctrs_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] block_base;
        logic [5:0]  prefix_length;
        logic [3:0]  error_code;
        logic [15:0] error_line;
        logic        last_of_run;
    } t_out_item;

    // parser states
    localparam logic [4:0] PS_START = 5'd1;
    localparam logic [4:0] PS_A1    = 5'd2;
    localparam logic [4:0] PS_A1D   = 5'd3;
    localparam logic [4:0] PS_A2    = 5'd4;
    localparam logic [4:0] PS_A2D   = 5'd5;
    localparam logic [4:0] PS_A3    = 5'd6;
    localparam logic [4:0] PS_A3D   = 5'd7;
    localparam logic [4:0] PS_A4    = 5'd8;
    localparam logic [4:0] PS_ADDR  = 5'd9;
    localparam logic [4:0] PS_DASH  = 5'd10;
    localparam logic [4:0] PS_B1    = 5'd11;
    localparam logic [4:0] PS_B1D   = 5'd12;
    localparam logic [4:0] PS_B2    = 5'd13;
    localparam logic [4:0] PS_B2D   = 5'd14;
    localparam logic [4:0] PS_B3    = 5'd15;
    localparam logic [4:0] PS_B3D   = 5'd16;
    localparam logic [4:0] PS_B4    = 5'd17;
    localparam logic [4:0] PS_SLASH = 5'd18;
    localparam logic [4:0] PS_WIDTH = 5'd19;

    localparam logic K_ADDR = 1'b0;
    localparam logic K_ERR  = 1'b1;

    localparam logic [3:0] E_NUM   = 4'd0;
    localparam logic [3:0] E_WIDTH = 4'd1;
    localparam logic [3:0] E_DOT   = 4'd2;
    localparam logic [3:0] E_DASH  = 4'd3;
    localparam logic [3:0] E_SLASH = 4'd4;
    localparam logic [3:0] E_SPACE = 4'd5;
    localparam logic [3:0] E_CHAR  = 4'd6;
    localparam logic [3:0] E_REV   = 4'd7;
    localparam logic [3:0] E_EARLY = 4'd8;

    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_DSH = 8'h2D;
    localparam logic [7:0] CH_SLS = 8'h2F;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam logic [15:0] LINE_MAX  = 16'hFFFF;
    localparam logic [7:0]  OCTET_MAX = 8'd255;
    localparam logic [7:0]  WIDTH_MAX = 8'd32;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic sel_r1;
        logic sel_split;
        logic init;
        logic shrink;
        logic step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic r0v;
        logic splitv;
        logic r1v;
        logic split_done;
        logic fits;
    } t_stat;

    function automatic t_out_item mk_addr(logic [31:0] base, logic [5:0] pfx);
        t_out_item r;
        r.result_kind   = K_ADDR;
        r.block_base    = base;
        r.prefix_length = pfx;
        r.error_code    = 4'd0;
        r.error_line    = 16'd0;
        r.last_of_run   = 1'b1;
        return r;
    endfunction

    function automatic t_out_item mk_err(logic [3:0] code, logic [15:0] line);
        t_out_item r;
        r.result_kind   = K_ERR;
        r.block_base    = 32'd0;
        r.prefix_length = 6'd0;
        r.error_code    = code;
        r.error_line    = line;
        r.last_of_run   = 1'b1;
        return r;
    endfunction

endpackage

// File: rtl/ctrs_dp.sv
module ctrs_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ctrs_pkg::t_in_item  i_in_data,
    input  ctrs_pkg::t_cmd      i_cmd,
    output ctrs_pkg::t_stat     o_stat,
    output ctrs_pkg::t_out_item o_out_data
);

    logic [4:0]  r_ps, n_ps;
    logic [7:0]  r_acc, n_acc;
    logic        r_te, n_te;
    logic [31:0] r_ab, n_ab;
    logic [31:0] r_rs, n_rs;
    logic [15:0] r_lc, n_lc;
    ctrs_pkg::t_out_item r_res0, r_res1, n_res0, n_res1;
    logic        r_r1v, n_r0v, n_r1v, n_splitv;
    logic [32:0] r_lo;
    logic [31:0] r_hi;
    logic [31:0] r_m;

    logic [4:0]  s;
    logic [31:0] shifted;
    logic [31:0] base_pre;
    logic [3:0]  dgt;
    logic [11:0] acc_t;
    logic [7:0]  lim;
    logic [7:0]  c;
    logic [5:0]  w;
    logic [32:0] lo_m1;
    logic [32:0] lo_plus_m;

    always_comb begin
        c        = i_in_data.char_code;
        dgt      = 4'(c - ctrs_pkg::CH_0);
        s        = (r_ps < ctrs_pkg::PS_START || r_ps > ctrs_pkg::PS_WIDTH) ?
                   ctrs_pkg::PS_START : r_ps;
        shifted  = {r_ab[23:0], r_acc};
        n_ps     = s;
        n_acc    = r_acc;
        n_te     = r_te;
        n_ab     = r_ab;
        n_rs     = r_rs;
        n_lc     = r_lc;
        n_r0v    = 1'b0;
        n_r1v    = 1'b0;
        n_splitv = 1'b0;
        n_res0   = ctrs_pkg::mk_addr(32'd0, 6'd0);
        n_res1   = n_res0;
        lim      = ctrs_pkg::OCTET_MAX;
        acc_t    = 12'd0;
        base_pre = 32'd0;
        w        = (r_acc > ctrs_pkg::WIDTH_MAX) ? 6'd32 : r_acc[5:0];
        if (!i_in_data.end_of_input && c == ctrs_pkg::CH_LF && r_lc != ctrs_pkg::LINE_MAX)
            n_lc = r_lc + 16'd1;

        if (i_in_data.end_of_input) begin
            if (!r_te) begin
                if (s == ctrs_pkg::PS_A4) begin
                    n_r0v  = 1'b1;
                    n_res0 = ctrs_pkg::mk_addr(shifted, 6'd32);
                end else if (s == ctrs_pkg::PS_ADDR) begin
                    n_r0v  = 1'b1;
                    n_res0 = ctrs_pkg::mk_addr(r_ab, 6'd32);
                end else if (s == ctrs_pkg::PS_B4) begin
                    if (r_rs > shifted) begin
                        n_r0v  = 1'b1;
                        n_res0 = ctrs_pkg::mk_err(ctrs_pkg::E_REV, n_lc);
                    end else begin
                        n_splitv = 1'b1;
                    end
                end else if (s == ctrs_pkg::PS_WIDTH) begin
                    n_r0v  = 1'b1;
                    n_res0 = ctrs_pkg::mk_addr((w == 6'd0) ? 32'd0 :
                             (r_ab & (32'hFFFFFFFF << (6'd32 - w))), w);
                end else if (s != ctrs_pkg::PS_START) begin
                    n_r0v  = 1'b1;
                    n_res0 = ctrs_pkg::mk_err(ctrs_pkg::E_EARLY, n_lc);
                end
            end
            n_ps  = ctrs_pkg::PS_START;
            n_te  = 1'b0;
            n_acc = 8'd0;
        end else if (c >= ctrs_pkg::CH_0 && c <= ctrs_pkg::CH_9) begin
            if (s == ctrs_pkg::PS_START) begin
                n_acc = {4'd0, dgt};
                n_te  = 1'b0;
                n_ps  = ctrs_pkg::PS_A1;
            end else if (s == ctrs_pkg::PS_ADDR) begin
                if (!r_te) begin
                    n_r0v  = 1'b1;
                    n_res0 = ctrs_pkg::mk_addr(r_ab, 6'd32);
                end
                n_acc = {4'd0, dgt};
                n_te  = 1'b0;
                n_ps  = ctrs_pkg::PS_A1;
            end else if (s == ctrs_pkg::PS_DASH || s == ctrs_pkg::PS_SLASH) begin
                if (!r_te)
                    n_acc = {4'd0, dgt};
                n_ps = s + 5'd1;
            end else begin
                if (s == ctrs_pkg::PS_A1D || s == ctrs_pkg::PS_A2D || s == ctrs_pkg::PS_A3D ||
                    s == ctrs_pkg::PS_B1D || s == ctrs_pkg::PS_B2D || s == ctrs_pkg::PS_B3D)
                    n_ps = s + 5'd1;
                if (s == ctrs_pkg::PS_WIDTH)
                    lim = ctrs_pkg::WIDTH_MAX;
                acc_t = {4'd0, r_acc} * 12'd10 + {8'd0, dgt};
                if (!r_te) begin
                    if (acc_t > {4'd0, lim}) begin
                        n_te   = 1'b1;
                        n_r0v  = 1'b1;
                        n_res0 = ctrs_pkg::mk_err((s == ctrs_pkg::PS_WIDTH) ?
                                 ctrs_pkg::E_WIDTH : ctrs_pkg::E_NUM, n_lc);
                    end else begin
                        n_acc = acc_t[7:0];
                    end
                end
            end
        end else if (c == ctrs_pkg::CH_DOT) begin
            if (s == ctrs_pkg::PS_A1 || s == ctrs_pkg::PS_B1 || s == ctrs_pkg::PS_A2 ||
                s == ctrs_pkg::PS_A3 || s == ctrs_pkg::PS_B2 || s == ctrs_pkg::PS_B3) begin
                base_pre = (s == ctrs_pkg::PS_A1 || s == ctrs_pkg::PS_B1) ? 32'd0 : r_ab;
                if (s == ctrs_pkg::PS_A1 || s == ctrs_pkg::PS_B1)
                    n_ab = 32'd0;
                if (!r_te) begin
                    n_ab  = {base_pre[23:0], r_acc};
                    n_acc = 8'd0;
                end
                n_ps = s + 5'd1;
            end else if (s == ctrs_pkg::PS_ADDR) begin
                if (!r_te) begin
                    n_r0v  = 1'b1;
                    n_res0 = ctrs_pkg::mk_addr(r_ab, 6'd32);
                    n_r1v  = 1'b1;
                    n_res1 = ctrs_pkg::mk_err(ctrs_pkg::E_DOT, n_lc);
                    n_te   = 1'b1;
                end
            end else if (!r_te) begin
                n_r0v  = 1'b1;
                n_res0 = ctrs_pkg::mk_err(ctrs_pkg::E_DOT, n_lc);
                n_te   = 1'b1;
            end
        end else if (c == ctrs_pkg::CH_DSH || c == ctrs_pkg::CH_SLS) begin
            if (s == ctrs_pkg::PS_A4 || s == ctrs_pkg::PS_ADDR) begin
                if (s == ctrs_pkg::PS_A4 && !r_te) begin
                    if (c == ctrs_pkg::CH_SLS)
                        n_ab = shifted;
                    else
                        n_rs = shifted;
                end
                if (s == ctrs_pkg::PS_ADDR && c == ctrs_pkg::CH_DSH)
                    n_rs = r_ab;
                n_ps = (c == ctrs_pkg::CH_SLS) ? ctrs_pkg::PS_SLASH : ctrs_pkg::PS_DASH;
            end else if (!r_te) begin
                n_r0v  = 1'b1;
                n_res0 = ctrs_pkg::mk_err((c == ctrs_pkg::CH_SLS) ?
                         ctrs_pkg::E_SLASH : ctrs_pkg::E_DASH, n_lc);
                n_te   = 1'b1;
            end
        end else if (c == ctrs_pkg::CH_LF || c == ctrs_pkg::CH_SP ||
                     c == ctrs_pkg::CH_TAB || c == ctrs_pkg::CH_CR) begin
            if ((s >= ctrs_pkg::PS_A1 && s <= ctrs_pkg::PS_A3D) ||
                (s >= ctrs_pkg::PS_B1 && s <= ctrs_pkg::PS_B3D)) begin
                // no suppression flag set here
                if (!r_te) begin
                    n_r0v  = 1'b1;
                    n_res0 = ctrs_pkg::mk_err(ctrs_pkg::E_SPACE, n_lc);
                end
                n_ps = ctrs_pkg::PS_START;
            end else if (s == ctrs_pkg::PS_A4) begin
                if (!r_te)
                    n_ab = shifted;
                n_ps = ctrs_pkg::PS_ADDR;
            end else if (s == ctrs_pkg::PS_B4) begin
                if (!r_te) begin
                    if (r_rs > shifted) begin
                        n_te   = 1'b1;
                        n_r0v  = 1'b1;
                        n_res0 = ctrs_pkg::mk_err(ctrs_pkg::E_REV, n_lc);
                    end else begin
                        n_splitv = 1'b1;
                    end
                end
                n_ps = ctrs_pkg::PS_START;
            end else if (s == ctrs_pkg::PS_WIDTH) begin
                if (!r_te) begin
                    n_r0v  = 1'b1;
                    n_res0 = ctrs_pkg::mk_addr((w == 6'd0) ? 32'd0 :
                             (r_ab & (32'hFFFFFFFF << (6'd32 - w))), w);
                end
                n_ps = ctrs_pkg::PS_START;
            end
        end else begin
            if (!r_te) begin
                n_r0v  = 1'b1;
                n_res0 = ctrs_pkg::mk_err(ctrs_pkg::E_CHAR, n_lc);
            end
            n_te = 1'b1;
            n_ps = ctrs_pkg::PS_A1;
        end
    end

    assign lo_m1     = r_lo - 33'd1;
    assign lo_plus_m = r_lo + {1'b0, r_m};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps  <= ctrs_pkg::PS_START;
            r_acc <= 8'd0;
            r_te  <= 1'b0;
            r_ab  <= 32'd0;
            r_rs  <= 32'd0;
            r_lc  <= 16'd1;
            r_r1v <= 1'b0;
            r_lo  <= 33'd0;
            r_hi  <= 32'd0;
        end else begin
            if (i_cmd.load) begin
                r_ps  <= n_ps;
                r_acc <= n_acc;
                r_te  <= n_te;
                r_ab  <= n_ab;
                r_rs  <= n_rs;
                r_lc  <= n_lc;
                r_r1v <= n_r1v;
                if (n_splitv) begin
                    r_lo <= {1'b0, r_rs};
                    r_hi <= shifted;
                end
            end
            if (i_cmd.step)
                r_lo <= lo_plus_m + 33'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res0 <= n_res0;
            r_res1 <= n_res1;
        end
        if (i_cmd.init)
            r_m <= lo_m1[31:0] & ~r_lo[31:0];
        else if (i_cmd.shrink && !o_stat.fits)
            r_m <= r_m >> 1;
    end

    assign o_stat.r0v        = n_r0v;
    assign o_stat.splitv     = n_splitv;
    assign o_stat.r1v        = r_r1v;
    assign o_stat.split_done = r_lo > {1'b0, r_hi};
    assign o_stat.fits       = lo_plus_m <= {1'b0, r_hi};

    always_comb begin
        if (i_cmd.sel_split) begin
            o_out_data             = ctrs_pkg::mk_addr(r_lo[31:0],
                                     6'd32 - 6'($countones(r_m)));
            o_out_data.last_of_run = (lo_plus_m == {1'b0, r_hi});
        end else if (i_cmd.sel_r1) begin
            o_out_data = r_res1;
        end else begin
            o_out_data             = r_res0;
            o_out_data.last_of_run = !r_r1v;
        end
    end

endmodule

// File: rtl/ctrs_ctrl.sv
module ctrs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  ctrs_pkg::t_stat i_stat,
    output ctrs_pkg::t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_R0     = 6'b000010,
        S_R1     = 6'b000100,
        S_SINIT  = 6'b001000,
        S_SHRINK = 6'b010000,
        S_SOUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   out_take;

    assign out_take    = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_R0) || (r_state == S_R1) || (r_state == S_SOUT);

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.sel_r1    = (r_state == S_R1);
        o_cmd.sel_split = (r_state == S_SOUT);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.r0v)
                        n_state = S_R0;
                    else if (i_stat.splitv)
                        n_state = S_SINIT;
                end
            end
            S_R0: begin
                if (out_take)
                    n_state = i_stat.r1v ? S_R1 : S_IDLE;
            end
            S_R1: begin
                if (out_take)
                    n_state = S_IDLE;
            end
            S_SINIT: begin
                o_cmd.init = 1'b1;
                n_state    = i_stat.split_done ? S_IDLE : S_SHRINK;
            end
            S_SHRINK: begin
                // halve the block until it fits under the high bound
                o_cmd.shrink = 1'b1;
                if (i_stat.fits)
                    n_state = S_SOUT;
            end
            S_SOUT: begin
                if (out_take) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_SINIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

endmodule

// File: rtl/cidr_text_parser_range_splitter.sv
// IPv4 text parser and CIDR range splitter.
// Input channel: one text byte per transaction (char_code), or an
// end_of_input marker that flushes the pending token. Output channel:
// CIDR blocks (base, prefix length) and numbered error reports; the
// final result caused by one input transaction carries last_of_run.
// A byte that yields no result does not stall the input; the next byte
// may follow at once. A byte with one or two results stalls the input
// until those are taken; the first is registered and shown in the next cycle.
// A range is split by a shrink loop: per block the init state takes the
// largest aligned block at the low bound, the shrink state halves it until
// it fits under the high bound and the output state presents it.
// While any result is pending the input is stalled; a stall on the
// output simply holds the current result.
// Reset (synchronous, active low) returns the parser to the start state,
// clears the error flag and sets the line count to one. No clearing pass.
`include "cidr_text_parser_range_splitter_macros.svh"
module cidr_text_parser_range_splitter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ctrs_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ctrs_pkg::t_out_item o_out_data
);

    ctrs_pkg::t_cmd  cmd;
    ctrs_pkg::t_stat stat;

    ctrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ctrs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

    `CTRS_ASSERT_IMP(a_no_accept_while_out, o_out_valid, o_in_stall, "input taken with result pending")
    `CTRS_ASSERT_NXT(a_last_ends_run, o_out_valid && !i_out_stall && o_out_data.last_of_run, !o_out_valid, "result after last_of_run")
    `CTRS_ASSERT_IMP(a_err_fields, o_out_valid && o_out_data.result_kind, o_out_data.block_base == 32'd0 && o_out_data.prefix_length == 6'd0, "error report with block fields")
    `CTRS_ASSERT_IMP(a_addr_fields, o_out_valid && !o_out_data.result_kind, o_out_data.prefix_length <= 6'd32 && o_out_data.error_line == 16'd0, "bad address block")

endmodule

// File: tb/tb.sv
module tb;
    import ctrs_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    cidr_text_parser_range_splitter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // parser shadow state
    logic [4:0]  p_state;
    logic [7:0]  p_acc;
    logic        p_err;
    logic [31:0] p_addr;
    logic [31:0] p_rstart;
    logic [15:0] p_line;

    t_out_item cidr_q[$];
    t_out_item run_buf[$];
    int        n_fail;
    int        n_items;
    int        n_results;
    int        n_blocks;
    int        n_errs;
    int        send_idle_pct;
    int        recv_stall_pct;
    logic      hold_recv;

    function automatic logic [31:0] shifted_addr();
        return {p_addr[23:0], p_acc};
    endfunction

    task automatic push_res(logic kind, logic [31:0] base, logic [5:0] pfx, logic [3:0] code);
        t_out_item r;
        r.result_kind   = kind;
        r.block_base    = base;
        r.prefix_length = pfx;
        r.error_code    = kind ? code : 4'd0;
        r.error_line    = kind ? p_line : 16'd0;
        r.last_of_run   = 1'b0;
        run_buf.push_back(r);
    endtask

    task automatic push_err(logic [3:0] code);
        if (!p_err) begin
            p_err = 1'b1;
            push_res(K_ERR, 32'd0, 6'd0, code);
        end
    endtask

    task automatic push_width(logic [31:0] a, logic [7:0] w);
        logic [31:0] base;
        logic [5:0]  wl;
        wl = (w > 32) ? 6'd32 : w[5:0];
        base = (wl == 0) ? 32'd0 : (a & (32'hFFFF_FFFF << (32 - wl)));
        push_res(K_ADDR, base, wl, E_NUM);
    endtask

    task automatic split_range(logic [31:0] lo, logic [31:0] hi);
        logic [32:0] low;
        logic [32:0] m;
        int          bits;
        if (lo > hi) begin
            p_err = 1'b0;
            push_err(E_REV);
            return;
        end
        low = {1'b0, lo};
        while (low <= {1'b0, hi}) begin
            m = ((low - 33'd1) & ~low) & 33'h0_FFFF_FFFF;
            while (low + m > {1'b0, hi}) m = m >> 1;
            bits = 0;
            for (logic [32:0] t = m; t != 0; t = t >> 1) bits++;
            push_res(K_ADDR, low[31:0], 6'(32 - bits), E_NUM);
            low = low + m + 33'd1;
        end
    endtask

    task automatic parse_digit(logic [7:0] d);
        logic [8:0] lim;
        logic [31:0] t;
        lim = 9'd255;
        case (p_state)
            PS_START: begin
                p_acc = d; p_err = 1'b0; p_state = PS_A1; return;
            end
            PS_ADDR: begin
                if (!p_err) push_res(K_ADDR, p_addr, 6'd32, E_NUM);
                p_acc = d; p_err = 1'b0; p_state = PS_A1; return;
            end
            PS_DASH, PS_SLASH: begin
                if (!p_err) p_acc = d;
                p_state = p_state + 5'd1; return;
            end
            PS_A1D, PS_A2D, PS_A3D, PS_B1D, PS_B2D, PS_B3D: p_state = p_state + 5'd1;
            PS_WIDTH: lim = 9'd32;
            default: ;
        endcase
        if (p_err) return;
        t = 32'(p_acc) * 10 + 32'(d);
        if (t > lim) push_err(lim == 32 ? E_WIDTH : E_NUM);
        else p_acc = t[7:0];
    endtask

    task automatic parse_dot();
        case (p_state)
            PS_A1, PS_B1, PS_A2, PS_A3, PS_B2, PS_B3: begin
                if (p_state == PS_A1 || p_state == PS_B1) p_addr = 32'd0;
                if (!p_err) begin
                    p_addr = shifted_addr(); p_acc = 8'd0;
                end
                p_state = p_state + 5'd1;
            end
            PS_ADDR: begin
                if (!p_err) push_res(K_ADDR, p_addr, 6'd32, E_NUM);
                push_err(E_DOT);
            end
            default: push_err(E_DOT);
        endcase
    endtask

    task automatic parse_mark(logic slash);
        if (p_state == PS_A4) begin
            if (!p_err) begin
                if (slash) p_addr = shifted_addr(); else p_rstart = shifted_addr();
            end
        end else if (p_state == PS_ADDR) begin
            if (!slash) p_rstart = p_addr;
        end else begin
            push_err(slash ? E_SLASH : E_DASH);
            return;
        end
        p_state = slash ? PS_SLASH : PS_DASH;
    endtask

    task automatic parse_space();
        if ((p_state >= PS_A1 && p_state <= PS_A3D) ||
            (p_state >= PS_B1 && p_state <= PS_B3D)) begin
            if (!p_err) push_res(K_ERR, 32'd0, 6'd0, E_SPACE);
            p_state = PS_START;
        end else if (p_state == PS_A4) begin
            if (!p_err) p_addr = shifted_addr();
            p_state = PS_ADDR;
        end else if (p_state == PS_B4) begin
            if (!p_err) split_range(p_rstart, shifted_addr());
            p_state = PS_START;
        end else if (p_state == PS_WIDTH) begin
            if (!p_err) push_width(p_addr, p_acc);
            p_state = PS_START;
        end
    endtask

    task automatic parse_flush();
        if (!p_err) begin
            if (p_state == PS_A4) push_res(K_ADDR, shifted_addr(), 6'd32, E_NUM);
            else if (p_state == PS_ADDR) push_res(K_ADDR, p_addr, 6'd32, E_NUM);
            else if (p_state == PS_B4) split_range(p_rstart, shifted_addr());
            else if (p_state == PS_WIDTH) push_width(p_addr, p_acc);
            else if (p_state >= PS_A1 && p_state <= PS_SLASH) push_err(E_EARLY);
        end
        p_state = PS_START;
        p_err = 1'b0;
        p_acc = 8'd0;
    endtask

    // stimulus queue of raw transactions
    t_in_item stim_q[$];
    // every prediction in order, kept for the fixed directed rows
    t_out_item fixed_q[$];

    // advance the shadow parser by one accepted transaction
    task automatic predict_cidr(t_in_item it);
        logic [7:0] c;
        c = it.char_code;
        run_buf.delete();
        if (p_state < PS_START || p_state > PS_WIDTH) p_state = PS_START;
        if (it.end_of_input) parse_flush();
        else if (c >= CH_0 && c <= CH_9) parse_digit(c - CH_0);
        else if (c == CH_DOT) parse_dot();
        else if (c == CH_DSH) parse_mark(1'b0);
        else if (c == CH_SLS) parse_mark(1'b1);
        else if (c == CH_LF || c == CH_SP || c == CH_TAB || c == CH_CR) begin
            if (c == CH_LF && p_line != LINE_MAX) p_line = p_line + 16'd1;
            parse_space();
        end else begin
            push_err(E_CHAR);
            p_state = PS_A1;
        end
        if (run_buf.size() > 0) run_buf[run_buf.size() - 1].last_of_run = 1'b1;
        foreach (run_buf[i]) begin
            cidr_q.push_back(run_buf[i]);
            fixed_q.push_back(run_buf[i]);
        end
    endtask

    task automatic add_ch(logic [7:0] c);
        t_in_item it;
        it.char_code = c; it.end_of_input = 1'b0;
        stim_q.push_back(it);
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++) add_ch(s[i]);
    endtask

    task automatic add_eoi(logic [7:0] junk);
        t_in_item it;
        it.char_code = junk; it.end_of_input = 1'b1;
        stim_q.push_back(it);
    endtask

    function automatic string rand_octet();
        case ($urandom_range(0, 5))
            0: return "0";
            1: return "255";
            2: return $sformatf("%0d", $urandom_range(256, 999));
            default: return $sformatf("%0d", $urandom_range(0, 255));
        endcase
    endfunction

    function automatic string rand_addr();
        return {rand_octet(), ".", rand_octet(), ".", rand_octet(), ".", rand_octet()};
    endfunction

    function automatic string rand_sep();
        case ($urandom_range(0, 3))
            0: return "\n";
            1: return "\t";
            2: return "\r";
            default: return " ";
        endcase
    endfunction

    // one well-formed-ish token, sometimes with a corrupted character
    task automatic add_rand_token();
        string s;
        int    k;
        case ($urandom_range(0, 3))
            0: s = rand_addr();
            1: s = {rand_addr(), "/", $sformatf("%0d", $urandom_range(0, 40))};
            default: begin
                // dash with or without spaces around it
                s = {rand_addr(), (($urandom_range(0, 1)) ? " - " : "-"), rand_addr()};
            end
        endcase
        if ($urandom_range(0, 9) == 0) begin
            k = $urandom_range(0, s.len() - 1);
            s[k] = 8'($urandom_range(0, 255));
        end
        add_str(s);
        if ($urandom_range(0, 9) == 0) add_eoi(8'($urandom_range(0, 255)));
        else add_str(rand_sep());
    endtask

    // directed table: char sequences; expectation fixed where obvious
    typedef struct {
        string     txt;
        logic      eoi;
        logic      has_fix;
        t_out_item fix;
    } t_row;

    t_row dir_rows[$];

    task automatic add_row(string txt, logic eoi, logic has_fix, t_out_item fix);
        t_row r;
        r.txt = txt; r.eoi = eoi; r.has_fix = has_fix; r.fix = fix;
        dir_rows.push_back(r);
    endtask

    // sender
    initial begin
        t_out_item none;
        none = mk_addr(32'd0, 6'd0);
        n_fail = 0; n_items = 0; n_results = 0; n_blocks = 0; n_errs = 0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_recv = 1'b0;
        p_state = PS_START; p_acc = 8'd0; p_err = 1'b0;
        p_addr = 32'd0; p_rstart = 32'd0; p_line = 16'd1;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in_data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row("0.0.0.0",         1'b1, 1'b1, mk_addr(32'h0000_0000, 6'd32));
        add_row("255.255.255.255", 1'b1, 1'b1, mk_addr(32'hFFFF_FFFF, 6'd32));
        add_row("256",             1'b0, 1'b1, mk_err(E_NUM, 16'd1));
        add_row(" 1.2.3.4/33",     1'b1, 1'b1, mk_err(E_WIDTH, 16'd1));
        add_row(" .",              1'b0, 1'b1, mk_err(E_DOT, 16'd1));
        add_row(" -",              1'b0, 1'b0, none);
        add_row(" /",              1'b0, 1'b0, none);
        add_row("\n1.2 ",          1'b0, 1'b1, mk_err(E_SPACE, 16'd2));
        add_row("x",               1'b1, 1'b1, mk_err(E_CHAR, 16'd2));
        add_row("9.9.9.9-1.1.1.1 ", 1'b0, 1'b1, mk_err(E_REV, 16'd2));
        add_row("1.2",             1'b1, 1'b1, mk_err(E_EARLY, 16'd2));
        add_row("10.1.2.3/0 ",     1'b0, 1'b1, mk_addr(32'd0, 6'd0));
        add_row("10.1.2.3/32\t",   1'b0, 1'b0, none);
        add_row("10.1.2.3/8\r",    1'b0, 1'b0, none);
        add_row("1.2.3.4 .",       1'b0, 1'b0, none);
        add_row("1.2.3.4 5.6.7.8 ", 1'b1, 1'b0, none);
        add_row("0.0.0.0-255.255.255.255 ", 1'b0, 1'b0, none);
        add_row("0.0.0.1-255.255.255.254 ", 1'b0, 1'b0, none);
        add_row("1.2.3.4 - 1.2.3.4", 1'b1, 1'b0, none);
        add_row("1.2.3.4/", 1'b1, 1'b1, mk_err(E_EARLY, 16'd2));
        add_row("x9.1.1.1 ", 1'b0, 1'b0, none);
        add_row("1.2.3.4 x.5 9", 1'b1, 1'b0, none);

        foreach (dir_rows[r]) begin
            int before_q;
            stim_q.delete();
            add_str(dir_rows[r].txt);
            if (dir_rows[r].eoi) add_eoi(8'hFF);
            before_q = fixed_q.size();
            drive_all();
            // the fixed row value must match the first prediction of the row
            if (dir_rows[r].has_fix) begin
                if (fixed_q.size() > before_q) begin
                    t_out_item f;
                    t_out_item p;
                    f = dir_rows[r].fix;
                    p = fixed_q[before_q];
                    if (f.result_kind != p.result_kind || f.block_base != p.block_base ||
                        f.prefix_length != p.prefix_length || f.error_code != p.error_code ||
                        f.error_line != p.error_line) begin
                        $error("row %0d: expected kind %0d base %h pfx %0d code %0d line %0d, got %p",
                               r, f.result_kind, f.block_base, f.prefix_length,
                               f.error_code, f.error_line, p);
                        n_fail++;
                    end
                end else begin
                    $error("row %0d: expected a result, none predicted", r);
                    n_fail++;
                end
            end
            wait_drain();
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            stim_q.delete();
            while (stim_q.size() < 24) add_rand_token();
            // noise bytes
            for (int i = 0; i < 8; i++) add_ch(8'($urandom_range(0, 255)));
            add_eoi(8'h00);
            if (ph == 2) hold_recv = 1'b1;
            drive_all();
            wait_drain();
        end

        i_in_valid <= 1'b0;
        repeat (20) @(posedge i_clk);
        $display("checked %0d input transactions, %0d results (%0d blocks, %0d errors)",
                 n_items, n_results, n_blocks, n_errs);
        $display("stimulus: directed rows, then random tokens under four idle mixes");
        if (n_fail == 0 && cidr_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    task automatic drive_all();
        while (stim_q.size() > 0) begin
            if (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_in_valid <= 1'b1;
                i_in_data  <= stim_q[0];
                @(posedge i_clk);
                while (o_in_stall) @(posedge i_clk);
                predict_cidr(stim_q.pop_front());
                n_items++;
                if (stim_q.size() == 0) i_in_valid <= 1'b0;
            end
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (cidr_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // receiver
    initial begin
        int hold_cnt;
        i_out_stall = 1'b0;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (hold_recv && hold_cnt < 300) begin
                hold_cnt++;
                i_out_stall <= 1'b1;
            end else begin
                if (hold_cnt >= 300) hold_recv = 1'b0;
                hold_cnt = hold_recv ? hold_cnt : 0;
                i_out_stall <= (recv_stall_pct != 0 &&
                                $urandom_range(1, 100) <= recv_stall_pct);
            end
        end
    end

    // checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            t_out_item e;
            if (cidr_q.size() == 0) begin
                $error("unexpected result %p", o_out_data);
                n_fail++;
            end else begin
                e = cidr_q.pop_front();
                n_results++;
                if (e.result_kind) n_errs++; else n_blocks++;
                if (o_out_data.result_kind != e.result_kind) begin
                    $error("result_kind exp %0d got %0d", e.result_kind, o_out_data.result_kind);
                    n_fail++;
                end
                if (o_out_data.block_base != e.block_base) begin
                    $error("block_base exp %h got %h", e.block_base, o_out_data.block_base);
                    n_fail++;
                end
                if (o_out_data.prefix_length != e.prefix_length) begin
                    $error("prefix_length exp %0d got %0d", e.prefix_length,
                           o_out_data.prefix_length);
                    n_fail++;
                end
                if (o_out_data.error_code != e.error_code) begin
                    $error("error_code exp %0d got %0d", e.error_code, o_out_data.error_code);
                    n_fail++;
                end
                if (o_out_data.error_line != e.error_line) begin
                    $error("error_line exp %0d got %0d", e.error_line, o_out_data.error_line);
                    n_fail++;
                end
                if (o_out_data.last_of_run != e.last_of_run) begin
                    $error("last_of_run exp %0d got %0d", e.last_of_run, o_out_data.last_of_run);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        #40000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
